/* hdl/c2e_pkg.sv */
package c2e_pkg;

  localparam logic [11:0] FirstYear   = 12'd1970;
  localparam logic [11:0] LastYear    = 12'd2099;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [3:0]  MonthFeb    = 4'd2;
  localparam logic [3:0]  MonthDec    = 4'd12;
  localparam logic [4:0]  LastHour    = 5'd23;
  localparam logic [5:0]  LastMinute  = 6'd59;
  localparam logic [5:0]  SecsPerMin  = 6'd60;

  // Decoded and checked fields, after the first stage.
  typedef struct packed {
    logic       ok;
    logic [7:0] year_off;
    logic [8:0] month_days;
    logic [4:0] day_off;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dec_t;

  // Whole days since the epoch and seconds into the day.
  typedef struct packed {
    logic        ok;
    logic [15:0] days;
    logic [16:0] tod;
  } sum_t;

  // Day count scaled to seconds.
  typedef struct packed {
    logic        ok;
    logic [31:0] day_secs;
    logic [16:0] tod;
  } prod_t;

  // Days before the first of a month in a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of a month; zero for a month code that means nothing.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] l;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
      4'd2:    l = leap ? 5'd29 : 5'd28;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

/* hdl/c2e_decode.sv */
module c2e_decode
  import c2e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output logic        valid_o,
  input  logic        ready_i,
  output dec_t        data_o
);

  logic        valid_q;
  dec_t        data_d, data_q;
  logic        leap;
  logic [4:0]  mlen;
  logic [11:0] year_diff;
  logic        year_ok, month_ok, day_ok, time_ok;

  // Within 1970..2099 the only century year is 2000, which is a leap year,
  // so divisibility by four decides. Outside the range the item is invalid.
  assign leap      = (year_i[1:0] == 2'b00);
  assign mlen      = month_len(month_i, leap);
  assign year_diff = year_i - FirstYear;

  assign year_ok  = (year_i >= FirstYear) && (year_i <= LastYear);
  assign month_ok = (month_i != 4'd0) && (month_i <= MonthDec);
  assign day_ok   = (day_i != 5'd0) && (day_i <= mlen);
  assign time_ok  = (hour_i <= LastHour) && (minute_i <= LastMinute) &&
                    (second_i <= LastMinute);

  always_comb begin
    data_d            = '0;
    data_d.ok         = year_ok && month_ok && day_ok && time_ok;
    data_d.year_off   = year_diff[7:0];
    data_d.month_days = cum_days(month_i) + {8'd0, (leap && (month_i > MonthFeb))};
    data_d.day_off    = day_i - 5'd1;
    data_d.hour       = hour_i;
    data_d.minute     = minute_i;
    data_d.second     = second_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/c2e_days.sv */
module c2e_days
  import c2e_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output sum_t data_o
);

  logic        valid_q;
  sum_t        data_d, data_q;
  logic [15:0] year_days;
  logic [7:0]  leap_cnt;
  logic [16:0] hour_secs;
  logic [11:0] min_secs;

  assign year_days = 16'({8'd0, data_i.year_off} * {7'd0, DaysPerYear});
  // Leap days between 1970 and the year before this one.
  assign leap_cnt  = 8'(({1'b0, data_i.year_off} + 9'd1) >> 2);
  assign hour_secs = 17'({12'd0, data_i.hour} * {5'd0, SecsPerHour});
  assign min_secs  = 12'({6'd0, data_i.minute} * {6'd0, SecsPerMin});

  always_comb begin
    data_d      = '0;
    data_d.ok   = data_i.ok;
    data_d.days = year_days + {8'd0, leap_cnt} + {7'd0, data_i.month_days} +
                  {11'd0, data_i.day_off};
    data_d.tod  = hour_secs + {5'd0, min_secs} + {11'd0, data_i.second};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/c2e_scale.sv */
module c2e_scale
  import c2e_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  sum_t  data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output prod_t data_o
);

  logic        valid_q;
  prod_t       data_d, data_q;
  logic [32:0] prod;

  // For a valid item the day count never exceeds 47481, so the product fits 32 bits.
  assign prod = {17'd0, data_i.days} * {16'd0, SecsPerDay};

  always_comb begin
    data_d          = '0;
    data_d.ok       = data_i.ok;
    data_d.day_secs = prod[31:0];
    data_d.tod      = data_i.tod;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/c2e_sum.sv */
module c2e_sum
  import c2e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  prod_t       data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        valid_res_o,
  output logic [31:0] epoch_count_o
);

  logic        valid_q;
  logic        res_ok_d, res_ok_q;
  logic [31:0] count_d, count_q;

  // An invalid item reports zero seconds.
  assign res_ok_d = data_i.ok;
  assign count_d  = data_i.ok ? (data_i.day_secs + {15'd0, data_i.tod}) : 32'd0;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_ok_q <= res_ok_d;
      count_q  <= count_d;
    end
  end

  assign valid_o       = valid_q;
  assign valid_res_o   = res_ok_q;
  assign epoch_count_o = count_q;

endmodule

/* hdl/calendar_to_epoch_seconds_unit.sv */
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   year_i, month_i, day_i, hour_i, minute_i, second_i
// out      out_valid_o / out_ready_i valid_res_o, epoch_count_o
//
// Four register stages: check and decode, day and time-of-day sums, scaling
// of days to seconds, final add. A transaction passes through them in that
// order; one transaction is taken every cycle unless every stage holds one
// and the output is stalled.
// Reset clears only the stage valid bits; the pipeline then starts empty.
// A stall at the output fills empty stages first; in_ready_o drops only when
// every stage holds a transaction.
module calendar_to_epoch_seconds_unit
  import c2e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [31:0] epoch_count_o
);

  logic  dec_valid, dec_ready;
  dec_t  dec_data;
  logic  sum_valid, sum_ready;
  sum_t  sum_data;
  logic  prod_valid, prod_ready;
  prod_t prod_data;

  c2e_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .year_i   (year_i),
    .month_i  (month_i),
    .day_i    (day_i),
    .hour_i   (hour_i),
    .minute_i (minute_i),
    .second_i (second_i),
    .valid_o  (dec_valid),
    .ready_i  (dec_ready),
    .data_o   (dec_data)
  );

  c2e_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  c2e_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum_data),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  c2e_sum u_sum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (prod_valid),
    .ready_o       (prod_ready),
    .data_i        (prod_data),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .valid_res_o   (valid_res_o),
    .epoch_count_o (epoch_count_o)
  );

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (epoch_count_o == 32'd0))
    else $error("invalid result carries nonzero seconds");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |-> (epoch_count_o <= 32'd4102444799))
    else $error("seconds count beyond end of 2099");

  a_full_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input blocked while the output is not stalled");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_o && out_ready_i) |=> in_ready_o)
    else $error("pipeline did not free a slot after output transaction");
`endif

endmodule

/* bench/calendar_to_epoch_seconds_unit_tb.sv */
module calendar_to_epoch_seconds_unit_tb;
  import c2e_pkg::FirstYear;
  import c2e_pkg::LastYear;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned ItemsPerTest = 375;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] epoch_count;
  } epoch_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [11:0] year_i = '0;
  logic [3:0]  month_i = '0;
  logic [4:0]  day_i = '0;
  logic [4:0]  hour_i = '0;
  logic [5:0]  minute_i = '0;
  logic [5:0]  second_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic [31:0] epoch_count_o;

  epoch_result_t pending_epochs[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;

  calendar_to_epoch_seconds_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .second_i      (second_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .valid_res_o   (valid_res_o),
    .epoch_count_o (epoch_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Number of leap years from year 1 through year n.
  function automatic int unsigned leap_years_through(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic epoch_result_t predict_epoch(input date_item_t d);
    int unsigned   y;
    int unsigned   m;
    int unsigned   days;
    int unsigned   acc;
    bit            leap;
    epoch_result_t r;
    y    = 32'(d.year);
    m    = 32'(d.month);
    leap = is_leap_year(y);
    r    = '0;
    if (y < FirstYear || y > LastYear) return r;
    if (m < 1 || m > 12) return r;
    if (d.day < 1 || d.day > month_length(m, leap)) return r;
    if (d.hour > 23 || d.minute > 59 || d.second > 59) return r;
    days = 365 * (y - 1970) + leap_years_through(y - 1) - leap_years_through(1969);
    for (int unsigned k = 1; k < m; k++) begin
      days += month_length(k, 1'b0);
    end
    if (m > 2 && leap) days += 1;
    days += d.day - 1;
    acc = days * 86400 + d.hour * 3600 + d.minute * 60 + d.second;
    r.valid_res   = 1'b1;
    r.epoch_count = acc;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Record each accepted input and check each accepted result.
  always @(posedge clk_i) begin
    epoch_result_t want;
    date_item_t    item;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_epochs.size() == 0) begin
          report_mismatch("unexpected result, epoch_count", epoch_count_o, 32'd0);
        end else begin
          want = pending_epochs.pop_front();
          if (valid_res_o !== want.valid_res)
            report_mismatch("valid_res", {31'd0, valid_res_o}, {31'd0, want.valid_res});
          if (epoch_count_o !== want.epoch_count)
            report_mismatch("epoch_count", epoch_count_o, want.epoch_count);
        end
      end
      if (in_valid_i && in_ready_o) begin
        item = '{year_i, month_i, day_i, hour_i, minute_i, second_i};
        pending_epochs.push_back(predict_epoch(item));
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Drives one transaction; valid is left high so a back-to-back item follows cleanly.
  task automatic send_date(input date_item_t d);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    year_i     <= d.year;
    month_i    <= d.month;
    day_i      <= d.day;
    hour_i     <= d.hour;
    minute_i   <= d.minute;
    second_i   <= d.second;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic date_item_t make_date(input int unsigned y, input int unsigned mo,
                                           input int unsigned dd, input int unsigned h,
                                           input int unsigned mi, input int unsigned s);
    date_item_t d;
    d.year   = 12'(y);
    d.month  = 4'(mo);
    d.day    = 5'(dd);
    d.hour   = 5'(h);
    d.minute = 6'(mi);
    d.second = 6'(s);
    return d;
  endfunction

  // Mostly well-formed dates, some with one field broken, the rest pure noise.
  function automatic date_item_t random_date();
    date_item_t  d;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(99);
    if ($urandom_range(9) == 0)
      d.year = ($urandom_range(1)) ? FirstYear : LastYear;
    else
      d.year = 12'($urandom_range(LastYear, FirstYear));
    d.month = 4'($urandom_range(12, 1));
    len = month_length(d.month, is_leap_year(d.year));
    d.day    = ($urandom_range(4) == 0) ? 5'(len) : 5'($urandom_range(len, 1));
    d.hour   = 5'($urandom_range(23));
    d.minute = 6'($urandom_range(59));
    d.second = 6'($urandom_range(59));
    if ($urandom_range(9) == 0) begin
      d.hour   = 5'd23;
      d.minute = 6'd59;
      d.second = 6'd59;
    end
    if (kind >= 70 && kind < 88) begin
      case ($urandom_range(5))
        0: d.year = ($urandom_range(1)) ? 12'($urandom_range(FirstYear - 1)) :
                                          12'($urandom_range(4095, LastYear + 1));
        1: d.month = ($urandom_range(1)) ? 4'd0 : 4'($urandom_range(15, 13));
        2: d.day = ($urandom_range(1) || len == 31) ? 5'd0 : 5'($urandom_range(31, len + 1));
        3: d.hour = 5'($urandom_range(31, 24));
        4: d.minute = 6'($urandom_range(63, 60));
        default: d.second = 6'($urandom_range(63, 60));
      endcase
    end else if (kind >= 88) begin
      d = {6'($urandom()), $urandom()};
    end
    return d;
  endfunction

  task automatic run_random_dates(input int unsigned count);
    repeat (count) send_date(random_date());
  endtask

  task automatic test_directed_dates();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_date(make_date(1970, 1, 1, 0, 0, 0));
    send_date(make_date(2099, 12, 31, 23, 59, 59));
    send_date(make_date(1969, 12, 31, 23, 59, 59));
    send_date(make_date(2100, 1, 1, 0, 0, 0));
    send_date(make_date(1900, 1, 1, 0, 0, 0));
    send_date(make_date(0, 0, 0, 0, 0, 0));
    send_date(make_date(4095, 15, 31, 31, 63, 63));
    send_date(make_date(2010, 0, 10, 10, 10, 10));
    send_date(make_date(2010, 13, 10, 10, 10, 10));
    send_date(make_date(2010, 15, 10, 10, 10, 10));
    send_date(make_date(2010, 6, 0, 10, 10, 10));
    send_date(make_date(2023, 4, 31, 12, 0, 0));
    send_date(make_date(2024, 2, 29, 12, 0, 0));
    send_date(make_date(2023, 2, 29, 12, 0, 0));
    send_date(make_date(2000, 2, 29, 0, 0, 0));
    send_date(make_date(2000, 3, 1, 0, 0, 0));
    send_date(make_date(2024, 2, 30, 0, 0, 0));
    send_date(make_date(2015, 7, 4, 24, 0, 0));
    send_date(make_date(2015, 7, 4, 12, 60, 0));
    send_date(make_date(2015, 7, 4, 12, 0, 60));
    send_date(make_date(2038, 1, 19, 3, 14, 7));
    send_date(make_date(2038, 1, 19, 3, 14, 8));
    send_date(make_date(2024, 12, 31, 23, 59, 59));
    send_date(make_date(2001, 1, 1, 0, 0, 0));
  endtask

  task automatic test_back_to_back();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_dates(ItemsPerTest);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct    = 83;
    receiver_stall_pct = 0;
    run_random_dates(ItemsPerTest);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 83;
    run_random_dates(ItemsPerTest);
  endtask

  task automatic test_both_sides_idle();
    sender_idle_pct    = 36;
    receiver_stall_pct = 36;
    run_random_dates(ItemsPerTest);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_dates();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/c2e_pkg.sv
hdl/c2e_decode.sv
hdl/c2e_days.sv
hdl/c2e_scale.sv
hdl/c2e_sum.sv
hdl/calendar_to_epoch_seconds_unit.sv
bench/calendar_to_epoch_seconds_unit_tb.sv
